[rtl/core/ole_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_pkg: shared definitions for the ordered list engine
// Request and status codes, field widths and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int DefCapacity = 16;

    localparam int ReqW = 4;
    localparam int ValW = 32;
    localparam int PosW = 8;
    localparam int StW  = 3;

    localparam logic [ReqW-1:0] REQ_INS_FRONT = 4'd0;
    localparam logic [ReqW-1:0] REQ_INS_TAIL  = 4'd1;
    localparam logic [ReqW-1:0] REQ_INS_AT    = 4'd2;
    localparam logic [ReqW-1:0] REQ_REM_FRONT = 4'd3;
    localparam logic [ReqW-1:0] REQ_REM_TAIL  = 4'd4;
    localparam logic [ReqW-1:0] REQ_REM_ALL   = 4'd5;
    localparam logic [ReqW-1:0] REQ_REM_AT    = 4'd6;
    localparam logic [ReqW-1:0] REQ_REM_VALUE = 4'd7;
    localparam logic [ReqW-1:0] REQ_TRAVERSE  = 4'd8;
    localparam logic [ReqW-1:0] REQ_SEARCH    = 4'd9;
    localparam logic [ReqW-1:0] REQ_COUNT     = 4'd10;
    localparam logic [ReqW-1:0] REQ_REVERSE   = 4'd11;

    localparam logic [StW-1:0] ST_OK       = 3'd0;
    localparam logic [StW-1:0] ST_EMPTY    = 3'd1;
    localparam logic [StW-1:0] ST_FULL     = 3'd2;
    localparam logic [StW-1:0] ST_BADPOS   = 3'd3;
    localparam logic [StW-1:0] ST_NOTFOUND = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic       load_req;   // capture request fields
        logic       rd_issue;   // read logical index k into the RAM
        logic       rd_prev;    // read logical index k-1 into the RAM
        logic       wr_insert;  // write captured value at logical index k
        logic       wr_shift;   // write last read data at logical index k
        logic       k_load_top; // k = count (insert shifting start)
        logic       k_load_pos; // k = start position of a remove
        logic       k_load_zero;
        logic       k_inc;
        logic       k_dec;
        logic       hold_data;  // keep RAM read data as the removed value
        logic       cnt_inc;
        logic       cnt_dec;
        logic       cnt_clear;
        logic       do_reverse;
    } ole_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [ReqW-1:0] req;
        logic            empty;
        logic            full;
        logic            pos_bad_ins;
        logic            pos_bad_rem;
        logic            k_at_top;    // k == target position (insert shift done)
        logic            k_last;      // k + 1 >= count
        logic            match;       // RAM read data equals request value
    } ole_sts_t;

endpackage : ole_pkg
`default_nettype wire

[rtl/core/ordered_list_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// Requests are handled one at a time: in_stall is high from acceptance until
//   the result is issued, and longer for each entry shifted or compared.
// Traverse gives one result per element, waiting while the output is stalled.
// Each shift write follows a registered RAM read of the entry it moves.
// Reset: asynchronous, active low; clears count, front, direction, walk index,
//   sequencer state and output valid flag.
// ----------------------------------------------------------------------------
// ordered_list_engine: bounded ordered list of signed values
// Controller and datapath around a circular element store.
// ----------------------------------------------------------------------------
module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int Capacity = DefCapacity
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [ReqW-1:0]        req_type,
    input  wire logic signed [ValW-1:0] item_value,
    input  wire logic [PosW-1:0]        position,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [StW-1:0]              status,
    output logic signed [ValW-1:0]      data_value,
    output logic [PosW-1:0]             found_position,
    output logic [PosW-1:0]             entry_count,
    output logic                        last
);

    ole_cmd_t               cmd;
    ole_sts_t               sts;
    logic signed [ValW-1:0] rd_value, held_value;
    logic [PosW-1:0]        k_plus_one, count_w;

    ole_datapath #(
        .Capacity (Capacity)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (req_type),
        .item_value (item_value),
        .position   (position),
        .cmd        (cmd),
        .sts        (sts),
        .rd_value   (rd_value),
        .held_value (held_value),
        .k_plus_one (k_plus_one),
        .count_out  (count_w)
    );

    ole_controller u_ctl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sts            (sts),
        .rd_value       (rd_value),
        .held_value     (held_value),
        .k_plus_one     (k_plus_one),
        .count_in       (count_w),
        .cmd            (cmd),
        .status         (status),
        .data_value     (data_value),
        .found_position (found_position),
        .entry_count    (entry_count),
        .last           (last)
    );

endmodule : ordered_list_engine
`default_nettype wire

[rtl/core/ole_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ole_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : ole_ram
`default_nettype wire

[rtl/core/ole_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_datapath: list storage and index arithmetic
// Holds the count, front slot and direction, maps logical indices to store
// slots and drives the element RAM.
// ----------------------------------------------------------------------------
module ole_datapath
    import ole_pkg::*;
#(
    parameter int Capacity = DefCapacity
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [ReqW-1:0]        req_type,
    input  wire logic signed [ValW-1:0] item_value,
    input  wire logic [PosW-1:0]        position,
    input  wire ole_cmd_t               cmd,
    output ole_sts_t                    sts,
    output logic signed [ValW-1:0]      rd_value,
    output logic signed [ValW-1:0]      held_value,
    output logic [PosW-1:0]             k_plus_one,
    output logic [PosW-1:0]             count_out
);

    localparam int AW = (Capacity > 1) ? $clog2(Capacity) : 1;
    localparam int CW = $clog2(Capacity + 1);
    localparam int KW = CW + 1;

    logic [ReqW-1:0]        req_reg;
    logic signed [ValW-1:0] val_reg;
    logic [PosW-1:0]        pos_reg;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          front_reg, front_next;
    logic                   rev_reg, rev_next;
    logic [KW-1:0]          k_reg, k_next;
    logic signed [ValW-1:0] held_reg;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr, slot_k, slot_kp1, slot_km1, slot_top;
    logic signed [ValW-1:0] ram_wdata, ram_rdata;

    // map logical index to store slot (index <= Capacity, front < Capacity)
    function automatic logic [AW-1:0] slot_map(input logic [AW-1:0] f,
                                               input logic          r,
                                               input logic [KW-1:0] i);
        logic [AW+1:0] s;
        logic [AW+1:0] cap;
        cap = (AW+2)'(Capacity);
        if (r)
        begin
            s = {2'b0, f} + cap - (AW+2)'(i);
        end
        else
        begin
            s = {2'b0, f} + (AW+2)'(i);
        end
        if (s >= cap)
        begin
            s = s - cap;
        end
        return AW'(s);
    endfunction

    assign slot_k   = slot_map(front_reg, rev_reg, k_reg);
    assign slot_kp1 = slot_map(front_reg, rev_reg, k_reg + KW'(1));
    assign slot_km1 = slot_map(front_reg, rev_reg, k_reg - KW'(1));
    assign slot_top = slot_map(front_reg, rev_reg, KW'(count_reg) - KW'(1));

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_type;
            val_reg <= item_value;
            pos_reg <= position;
        end
        if (cmd.hold_data)
        begin
            held_reg <= ram_rdata;
        end
    end

    // list control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            front_reg <= '0;
            rev_reg   <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            front_reg <= front_next;
            rev_reg   <= rev_next;
            k_reg     <= k_next;
        end
    end

    // next count, orientation and walk index
    always_comb
    begin
        count_next = count_reg;
        front_next = front_reg;
        rev_next   = rev_reg;
        k_next     = k_reg;
        priority if (cmd.cnt_clear)
        begin
            count_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.do_reverse && count_reg >= CW'(2))
        begin
            front_next = slot_top;
            rev_next   = ~rev_reg;
        end
        priority if (cmd.k_load_top)
        begin
            k_next = KW'(count_reg);
        end
        else if (cmd.k_load_pos)
        begin
            unique case (req_reg)
                REQ_INS_FRONT, REQ_REM_FRONT: k_next = '0;
                REQ_INS_TAIL:                 k_next = KW'(count_reg);
                REQ_REM_TAIL:                 k_next = KW'(count_reg) - KW'(1);
                default:                      k_next = KW'(pos_reg) - KW'(1);
            endcase
        end
        else if (cmd.k_load_zero)
        begin
            k_next = '0;
        end
        else if (cmd.k_inc)
        begin
            k_next = k_reg + KW'(1);
        end
        else if (cmd.k_dec)
        begin
            k_next = k_reg - KW'(1);
        end
    end

    // RAM port selection: shift writes move last read data into slot k
    always_comb
    begin
        ram_we    = cmd.wr_insert | cmd.wr_shift;
        ram_waddr = slot_k;
        ram_wdata = cmd.wr_insert ? val_reg : ram_rdata;
        ram_raddr = cmd.rd_prev ? slot_km1 : (cmd.rd_issue ? slot_k : slot_kp1);
    end

    ole_ram #(
        .Width (ValW),
        .Depth (Capacity)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // status to the controller
    logic [KW-1:0] ins_target;
    always_comb
    begin
        unique case (req_reg)
            REQ_INS_FRONT: ins_target = '0;
            REQ_INS_TAIL:  ins_target = KW'(count_reg);
            default:       ins_target = KW'(pos_reg) - KW'(1);
        endcase
        sts.req         = req_reg;
        sts.empty       = (count_reg == '0);
        sts.full        = (count_reg >= CW'(Capacity));
        sts.pos_bad_ins = (pos_reg == '0) ||
                          ({1'b0, pos_reg} > (PosW+1)'(count_reg) + (PosW+1)'(1));
        sts.pos_bad_rem = (pos_reg == '0) || ({1'b0, pos_reg} > (PosW+1)'(count_reg));
        sts.k_at_top    = (k_reg == ins_target);
        sts.k_last      = (k_reg + KW'(1) >= KW'(count_reg));
        sts.match       = (ram_rdata == val_reg);
    end

    assign rd_value   = ram_rdata;
    assign held_value = held_reg;
    assign k_plus_one = PosW'(k_reg + KW'(1));
    assign count_out  = PosW'(count_next);

endmodule : ole_datapath
`default_nettype wire

[rtl/core/ole_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_controller: request sequencer
// Decodes a request, steps the datapath through shifts, walks and reads,
// and fills the output register.
// ----------------------------------------------------------------------------
module ole_controller
    import ole_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    input  wire ole_sts_t               sts,
    input  wire logic signed [ValW-1:0] rd_value,
    input  wire logic signed [ValW-1:0] held_value,
    input  wire logic [PosW-1:0]        k_plus_one,
    input  wire logic [PosW-1:0]        count_in,
    output ole_cmd_t                    cmd,
    output logic [StW-1:0]              status,
    output logic signed [ValW-1:0]      data_value,
    output logic [PosW-1:0]             found_position,
    output logic [PosW-1:0]             entry_count,
    output logic                        last
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_INS      = 4'd2;  // read k-1, or place the value
    localparam logic [3:0] S_INS_WR   = 4'd3;  // copy k-1 up into k
    localparam logic [3:0] S_READ     = 4'd4;  // read of slot k in flight
    localparam logic [3:0] S_REM_HOLD = 4'd5;  // keep the removed value
    localparam logic [3:0] S_REM      = 4'd6;  // read k+1, or finish
    localparam logic [3:0] S_REM_WR   = 4'd7;  // copy k+1 down into k
    localparam logic [3:0] S_SCAN     = 4'd8;  // compare for value search
    localparam logic [3:0] S_TRAV     = 4'd9;  // emit one element
    localparam logic [3:0] S_OUT      = 4'd10; // issue the single result

    logic [3:0]             state_reg, state_next;
    logic                   ov_reg, ov_next;
    logic [StW-1:0]         st_reg, st_next;
    logic signed [ValW-1:0] dv_reg, dv_next;
    logic [PosW-1:0]        fp_reg, fp_next;
    logic [PosW-1:0]        ec_reg, ec_next;
    logic                   last_reg, last_next;
    logic                   out_free;

    assign out_free  = !ov_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        dv_reg   <= dv_next;
        fp_reg   <= fp_next;
        ec_reg   <= ec_next;
        last_reg <= last_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        st_next    = st_reg;
        dv_next    = dv_reg;
        fp_next    = fp_reg;
        ec_next    = ec_reg;
        last_next  = last_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // output register must be free before any result is built
                if (out_free)
                begin
                    st_next   = ST_OK;
                    dv_next   = '0;
                    fp_next   = '0;
                    last_next = 1'b1;
                    unique case (sts.req)
                        REQ_INS_FRONT, REQ_INS_TAIL, REQ_INS_AT:
                        begin
                            if (sts.req == REQ_INS_AT && sts.pos_bad_ins)
                            begin
                                st_next = ST_BADPOS;
                                state_next = S_OUT;
                            end
                            else if (sts.full)
                            begin
                                st_next = ST_FULL;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                cmd.k_load_top = 1'b1;
                                state_next = S_INS;
                            end
                        end
                        REQ_REM_FRONT, REQ_REM_TAIL, REQ_REM_AT:
                        begin
                            if (sts.empty)
                            begin
                                st_next = ST_EMPTY;
                                state_next = S_OUT;
                            end
                            else if (sts.req == REQ_REM_AT && sts.pos_bad_rem)
                            begin
                                st_next = ST_BADPOS;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                cmd.k_load_pos = 1'b1;
                                state_next     = S_READ;
                            end
                        end
                        REQ_REM_ALL:
                        begin
                            if (sts.empty)
                            begin
                                st_next = ST_EMPTY;
                            end
                            cmd.cnt_clear = 1'b1;
                            state_next = S_OUT;
                        end
                        REQ_REM_VALUE, REQ_SEARCH, REQ_TRAVERSE:
                        begin
                            if (sts.empty)
                            begin
                                st_next = ST_EMPTY;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                cmd.k_load_zero = 1'b1;
                                state_next      = S_READ;
                            end
                        end
                        REQ_REVERSE:
                        begin
                            if (sts.empty)
                            begin
                                st_next = ST_EMPTY;
                            end
                            cmd.do_reverse = 1'b1;
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                // place the value once k reaches the target, else fetch k-1
                if (sts.k_at_top)
                begin
                    cmd.wr_insert = 1'b1;
                    cmd.cnt_inc   = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                // data of k-1 is valid now; move it up and step down
                cmd.wr_shift = 1'b1;
                cmd.k_dec    = 1'b1;
                state_next   = S_INS;
            end
            S_READ:
            begin
                // issue the read of slot k; data is valid next cycle
                cmd.rd_issue = 1'b1;
                unique case (sts.req)
                    REQ_REM_FRONT, REQ_REM_TAIL, REQ_REM_AT: state_next = S_REM_HOLD;
                    REQ_TRAVERSE:                            state_next = S_TRAV;
                    default:                                 state_next = S_SCAN;
                endcase
            end
            S_REM_HOLD:
            begin
                cmd.hold_data = 1'b1;
                state_next    = S_REM;
            end
            S_REM:
            begin
                // slot k+1 read is issued by default; copy it down next cycle
                if (sts.k_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    dv_next     = held_value;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.k_inc    = 1'b1;
                state_next   = S_REM;
            end
            S_SCAN:
            begin
                if (sts.match)
                begin
                    fp_next = k_plus_one;
                    if (sts.req == REQ_REM_VALUE)
                    begin
                        cmd.hold_data = 1'b1;
                        state_next    = S_REM;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else if (sts.k_last)
                begin
                    st_next    = ST_NOTFOUND;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_TRAV:
            begin
                // keep re-reading slot k so the data holds while stalled
                cmd.rd_issue = 1'b1;
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    st_next   = ST_OK;
                    dv_next   = rd_value;
                    fp_next   = k_plus_one;
                    ec_next   = count_in;
                    last_next = sts.k_last;
                    if (sts.k_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_OUT:
            begin
                ov_next    = 1'b1;
                ec_next    = count_in;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // drive the result ports from the output register
    assign status         = st_reg;
    assign data_value     = dv_reg;
    assign found_position = fp_reg;
    assign entry_count    = ec_reg;
    assign last           = last_reg;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg && $stable(dv_reg))
        else $error("result changed under stall");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input taken while busy");
    a_decode_once: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(state_reg) == S_IDLE && $past(in_valid)
        |-> state_reg == S_DECODE)
        else $error("request not decoded");

endmodule : ole_controller
`default_nettype wire

[tb/tb_ordered_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine: self-checking bench for the ordered list engine
// A behavioural list model predicts every result of each accepted request;
// a monitor compares results field by field in order, with random gaps and
// stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine;
    import ole_pkg::*;

    localparam int Cap = 16;
    localparam int CycleLimit = 400000;
    localparam int HoldCycles = 300;
    localparam logic [ReqW-1:0] ReqUnused = 4'd15;

    typedef struct packed {
        logic [StW-1:0]         st;
        logic signed [ValW-1:0] data;
        logic [PosW-1:0]        fpos;
        logic [PosW-1:0]        cnt;
        logic                   lst;
    } list_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [ReqW-1:0] req_type;
    logic signed [ValW-1:0] item_value;
    logic [PosW-1:0] position;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [StW-1:0] status;
    logic signed [ValW-1:0] data_value;
    logic [PosW-1:0] found_position;
    logic [PosW-1:0] entry_count;
    logic last;

    // list contents, front first
    logic signed [ValW-1:0] list_q[$];
    list_result_t expected_q[$];
    int errors = 0;
    int cycles = 0;
    bit calm = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    int hold_off = 0;

    ordered_list_engine #(.Capacity(Cap)) dut (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // build the expected results of one request
    function automatic void predict_list(logic [ReqW-1:0] rq,
                                         logic signed [ValW-1:0] v,
                                         logic [PosW-1:0] p);
        list_result_t r;
        int idx;
        r = '0;
        r.lst = 1;
        idx = -1;
        case (rq)
            REQ_INS_FRONT, REQ_INS_TAIL, REQ_INS_AT:
            begin
                if (rq == REQ_INS_AT && (p < 1 || p > list_q.size() + 1))
                    r.st = ST_BADPOS;
                else if (list_q.size() >= Cap)
                    r.st = ST_FULL;
                else if (rq == REQ_INS_FRONT)
                    list_q.push_front(v);
                else if (rq == REQ_INS_TAIL)
                    list_q.push_back(v);
                else
                    list_q.insert(p - 1, v);
            end
            REQ_REM_FRONT, REQ_REM_TAIL, REQ_REM_AT:
            begin
                if (list_q.size() == 0)
                    r.st = ST_EMPTY;
                else if (rq == REQ_REM_AT && (p < 1 || p > list_q.size()))
                    r.st = ST_BADPOS;
                else
                begin
                    idx = (rq == REQ_REM_FRONT) ? 0 :
                          (rq == REQ_REM_TAIL) ? list_q.size() - 1 : p - 1;
                    r.data = list_q[idx];
                    list_q.delete(idx);
                end
            end
            REQ_REM_ALL:
            begin
                if (list_q.size() == 0)
                    r.st = ST_EMPTY;
                list_q.delete();
            end
            REQ_REM_VALUE, REQ_SEARCH:
            begin
                if (list_q.size() == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    foreach (list_q[k])
                        if (idx < 0 && list_q[k] == v)
                            idx = k;
                    if (idx < 0)
                        r.st = ST_NOTFOUND;
                    else
                    begin
                        r.fpos = PosW'(idx + 1);
                        if (rq == REQ_REM_VALUE)
                        begin
                            r.data = list_q[idx];
                            list_q.delete(idx);
                        end
                    end
                end
            end
            REQ_TRAVERSE:
            begin
                if (list_q.size() == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    foreach (list_q[k])
                    begin
                        r.data = list_q[k];
                        r.fpos = PosW'(k + 1);
                        r.cnt = PosW'(list_q.size());
                        r.lst = (k + 1 == list_q.size());
                        expected_q.push_back(r);
                    end
                    return;
                end
            end
            REQ_REVERSE:
            begin
                if (list_q.size() == 0)
                    r.st = ST_EMPTY;
                else
                    list_q.reverse();
            end
            default: ;
        endcase
        r.cnt = PosW'(list_q.size());
        expected_q.push_back(r);
    endfunction

    // send one transaction, predicting on acceptance
    task automatic send_request(logic [ReqW-1:0] rq, logic signed [ValW-1:0] v,
                                logic [PosW-1:0] p);
        while (!calm && $urandom_range(99) < 7)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        req_type <= rq;
        item_value <= v;
        position <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_list(rq, v, p);
        @(negedge clk);
    endtask

    function automatic logic signed [ValW-1:0] pick_value();
        // small pool so searches and removals by value hit often
        if ($urandom_range(3) != 0)
            return $signed(ValW'($urandom_range(9)) - 4);
        return $signed($urandom);
    endfunction

    task automatic wait_drained();
        in_valid <= 0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (2 * Cap + 10) @(negedge clk);
    endtask

    task automatic test_empty_cases();
        send_request(REQ_REM_FRONT, 0, 0);
        send_request(REQ_REM_TAIL, 0, 0);
        send_request(REQ_REM_AT, 0, 1);
        send_request(REQ_REM_VALUE, 5, 0);
        send_request(REQ_SEARCH, 5, 0);
        send_request(REQ_TRAVERSE, 0, 0);
        send_request(REQ_REVERSE, 0, 0);
        send_request(REQ_REM_ALL, 0, 0);
        send_request(REQ_COUNT, 0, 0);
        send_request(ReqUnused, 0, 0);
        send_request(REQ_INS_AT, 1, 0);
        send_request(REQ_INS_AT, 1, 2);
    endtask

    task automatic test_extremes();
        send_request(REQ_INS_AT, 32'sh7fffffff, 1);
        send_request(REQ_REVERSE, 0, 0);
        send_request(REQ_INS_FRONT, 32'sh80000000, 0);
        send_request(REQ_INS_TAIL, -1, 0);
        send_request(REQ_SEARCH, -1, 0);
        send_request(REQ_SEARCH, 77, 0);
        send_request(REQ_REM_AT, 0, 255);
        send_request(REQ_REM_AT, 0, 4);
        send_request(REQ_REVERSE, 0, 0);
        send_request(REQ_TRAVERSE, 0, 0);
        send_request(REQ_REM_VALUE, 32'sh7fffffff, 0);
        send_request(REQ_INS_AT, 9, 8'd255);
        send_request(REQ_INS_AT, 9, 2);
    endtask

    // fill past capacity, starting under the long output hold-off
    task automatic test_full_and_backpressure();
        hold_req = 1;
        for (int k = 0; k < Cap + 2; k++)
            send_request(REQ_INS_TAIL, pick_value(), 0);
        send_request(REQ_INS_AT, 3, 5);
        send_request(REQ_TRAVERSE, 0, 0);
        send_request(REQ_REVERSE, 0, 0);
        send_request(REQ_TRAVERSE, 0, 0);
        send_request(REQ_REM_ALL, 0, 0);
    endtask

    task automatic test_random_mix();
        logic [ReqW-1:0] rq;
        for (int n = 0; n < 372; n++)
        begin
            calm = (n >= 150 && n < 220);
            if ($urandom_range(9) < 6)
                rq = (list_q.size() < 8) ? ReqW'($urandom_range(2)) :
                                           ReqW'($urandom_range(11));
            else
                rq = ReqW'($urandom_range(15));
            send_request(rq, pick_value(),
                         $urandom_range(3) == 0 ? PosW'($urandom) :
                                                  PosW'($urandom_range(list_q.size() + 1)));
        end
        calm = 0;
    endtask

    // receiver stall: random, or a counted hold-off
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            out_stall <= 1;
            hold_off <= HoldCycles;
            hold_done <= 1;
        end
        else if (hold_off > 0)
        begin
            out_stall <= 1;
            hold_off <= hold_off - 1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 7);
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        list_result_t e;
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result status=%0d data=%0d", status, data_value);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (status !== e.st)
                begin
                    $error("status exp %0d got %0d", e.st, status);
                    errors++;
                end
                if (data_value !== e.data)
                begin
                    $error("data_value exp %0d got %0d", e.data, data_value);
                    errors++;
                end
                if (found_position !== e.fpos)
                begin
                    $error("found_position exp %0d got %0d", e.fpos, found_position);
                    errors++;
                end
                if (entry_count !== e.cnt)
                begin
                    $error("entry_count exp %0d got %0d", e.cnt, entry_count);
                    errors++;
                end
                if (last !== e.lst)
                begin
                    $error("last exp %0d got %0d", e.lst, last);
                    errors++;
                end
            end
        end
        if (cycles > CycleLimit)
        begin
            $display("tb_ordered_list_engine NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        req_type = '0;
        item_value = '0;
        position = '0;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_empty_cases();
        test_extremes();
        test_full_and_backpressure();
        test_random_mix();
        wait_drained();
        if (errors == 0 && expected_q.size() == 0)
            $display("tb_ordered_list_engine OK");
        else
            $display("tb_ordered_list_engine NOT OK");
        $finish;
    end
endmodule
